// File: rtl/dwr_pkg.sv
// ----------------------------------------------------------------------------
// dwr_pkg
// Shared types and constants for the double-ended queue with reversal.
// ----------------------------------------------------------------------------
package dwr_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int DATA_W        = 32;
  localparam int COUNT_W       = 11;

  typedef enum logic [1:0] {
    ACT_INS_HEAD = 2'd0,
    ACT_INS_TAIL = 2'd1,
    ACT_REM_HEAD = 2'd2,
    ACT_REVERSE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

endpackage

// File: rtl/dwr_ram.sv
// ----------------------------------------------------------------------------
// dwr_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module dwr_ram #(
  parameter int WIDTH = dwr_pkg::DATA_W,
  parameter int DEPTH = dwr_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/deque_with_reverse.sv
// ----------------------------------------------------------------------------
// deque_with_reverse
// Bounded double-ended queue of signed 32-bit values held in a circular RAM,
// with whole-queue reversal done by flipping an orientation flag.
// ----------------------------------------------------------------------------
// Inserts, reversals and failed removes register their result at the
// accepting edge; a new transaction may follow at once unless the output
// is stalled. A successful remove reads the registered-read element RAM and
// stalls input in the read state until the removed value is registered.
// Synchronous reset empties the queue and clears the flag; RAM contents are
// not cleared and no clearing pass is needed.
module deque_with_reverse #(
  parameter int DEPTH = dwr_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  dwr_pkg::action_t                  action,
  input  logic signed [dwr_pkg::DATA_W-1:0] item_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              ok,
  output logic signed [dwr_pkg::DATA_W-1:0] removed_value,
  output logic [dwr_pkg::COUNT_W-1:0]       count
);

  import dwr_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_t        state, state_next;
  logic [IW-1:0] front_idx, front_idx_next;
  logic [IW-1:0] back_idx, back_idx_next;
  logic [CW-1:0] elem_count, elem_count_next;
  logic          reversed, reversed_next;

  logic          accept;
  logic          out_take;
  logic          at_front;
  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  logic [DATA_W-1:0] rdata;
  logic          res_load;
  logic          res_ok;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  assign out_take = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign at_front = (action == ACT_INS_HEAD) == !reversed;

  always_comb begin
    state_next      = state;
    front_idx_next  = front_idx;
    back_idx_next   = back_idx;
    elem_count_next = elem_count;
    reversed_next   = reversed;
    we              = 1'b0;
    re              = 1'b0;
    waddr           = back_idx;
    raddr           = front_idx;
    res_load        = 1'b0;
    res_ok          = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_INS_HEAD, ACT_INS_TAIL: begin
              res_load = 1'b1;
              if (elem_count != FULL_CNT) begin
                res_ok          = 1'b1;
                we              = 1'b1;
                elem_count_next = elem_count + 1'b1;
                if (at_front) begin
                  front_idx_next = idx_dec(front_idx);
                  waddr          = idx_dec(front_idx);
                end else begin
                  back_idx_next = idx_inc(back_idx);
                  waddr         = back_idx;
                end
              end
            end
            ACT_REM_HEAD: begin
              if (elem_count != '0) begin
                re              = 1'b1;
                elem_count_next = elem_count - 1'b1;
                state_next      = S_READ;
                if (reversed) begin
                  back_idx_next = idx_dec(back_idx);
                  raddr         = idx_dec(back_idx);
                end else begin
                  front_idx_next = idx_inc(front_idx);
                  raddr          = front_idx;
                end
              end else begin
                res_load = 1'b1;
              end
            end
            default: begin
              res_load      = 1'b1;
              res_ok        = 1'b1;
              reversed_next = !reversed;
            end
          endcase
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  dwr_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(item_value),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      front_idx  <= '0;
      back_idx   <= '0;
      elem_count <= '0;
      reversed   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      front_idx  <= front_idx_next;
      back_idx   <= back_idx_next;
      elem_count <= elem_count_next;
      reversed   <= reversed_next;
      if (res_load || state == S_READ) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      count         <= COUNT_W'(elem_count_next);
      ok            <= (action == ACT_REM_HEAD) ? (elem_count != '0) : res_ok;
      removed_value <= '0;
    end else if (state == S_READ) begin
      removed_value <= rdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    elem_count <= FULL_CNT)
    else $error("element count exceeds capacity");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (elem_count == '0) |-> (front_idx == back_idx))
    else $error("empty queue with unequal pointers");

  a_read_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !out_valid)
    else $error("result register busy during a remove");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (removed_value == '0))
    else $error("failed transaction reports a nonzero value");

  a_remove_read: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_REM_HEAD && elem_count != '0) |=> (state == S_READ))
    else $error("remove did not enter the read cycle");

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the double-ended queue with reversal. A driver
// feeds operations from a backlog and predicts each accepted transaction on
// a shadow copy of the circular store. A monitor compares every result with
// the oldest prediction, while both sides stall or idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import dwr_pkg::*;

  localparam int QDEPTH      = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    action_t                  op;
    logic signed [DATA_W-1:0] val;
  } deque_op_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] removed;
    logic [COUNT_W-1:0]       count;
  } deque_outcome_t;

  logic                     clk        = 1'b0;
  logic                     rst        = 1'b1;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  action_t                  action     = ACT_INS_HEAD;
  logic signed [DATA_W-1:0] item_value = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic                     ok;
  logic signed [DATA_W-1:0] removed_value;
  logic [COUNT_W-1:0]       count;

  deque_op_t      op_backlog[$];
  deque_op_t      staged_op;
  deque_outcome_t op_outcomes[$];
  deque_outcome_t want;

  logic signed [DATA_W-1:0] shadow_store [QDEPTH];
  int  phys_front = 0;
  int  phys_back  = 0;
  int  held       = 0;
  bit  flipped    = 1'b0;

  int  gen_level     = 0;
  int  send_idle_pct = 31;
  int  recv_idle_pct = 84;
  int  mismatches    = 0;
  int  cycle_count   = 0;

  deque_with_reverse i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .item_value   (item_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ok           (ok),
    .removed_value(removed_value),
    .count        (count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic deque_outcome_t apply_deque_op(action_t op,
                                                   logic signed [DATA_W-1:0] val);
    deque_outcome_t res;
    bit             at_front;
    res = '0;
    case (op)
      ACT_INS_HEAD, ACT_INS_TAIL: begin
        if (held < QDEPTH) begin
          at_front = ((op == ACT_INS_HEAD) == !flipped);
          if (at_front) begin
            phys_front = (phys_front == 0) ? QDEPTH - 1 : phys_front - 1;
            shadow_store[phys_front] = val;
          end else begin
            shadow_store[phys_back] = val;
            phys_back = (phys_back == QDEPTH - 1) ? 0 : phys_back + 1;
          end
          held++;
          res.ok = 1'b1;
        end
      end
      ACT_REM_HEAD: begin
        if (held != 0) begin
          if (flipped) begin
            phys_back = (phys_back == 0) ? QDEPTH - 1 : phys_back - 1;
            res.removed = shadow_store[phys_back];
          end else begin
            res.removed = shadow_store[phys_front];
            phys_front = (phys_front == QDEPTH - 1) ? 0 : phys_front + 1;
          end
          held--;
          res.ok = 1'b1;
        end
      end
      default: begin
        flipped = !flipped;
        res.ok = 1'b1;
      end
    endcase
    res.count = held[COUNT_W-1:0];
    return res;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return {1'b1, {(DATA_W-1){1'b0}}};
      1:       return {1'b0, {(DATA_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(action_t op, logic signed [DATA_W-1:0] val);
    op_backlog.push_back('{op, val});
    if ((op == ACT_INS_HEAD || op == ACT_INS_TAIL) && gen_level < QDEPTH) begin
      gen_level++;
    end else if (op == ACT_REM_HEAD && gen_level > 0) begin
      gen_level--;
    end
  endtask

  task automatic queue_mix(int n, int ins_pct, int rem_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < ins_pct) begin
        queue_op($urandom_range(1) ? ACT_INS_TAIL : ACT_INS_HEAD, pick_value());
      end else if (r < ins_pct + rem_pct) begin
        queue_op(ACT_REM_HEAD, $urandom);
      end else begin
        queue_op(ACT_REVERSE, $urandom);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        op_outcomes.push_back(apply_deque_op(action, item_value));
      end
      if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        staged_op = op_backlog.pop_front();
        in_valid   <= 1'b1;
        action     <= staged_op.op;
        item_value <= staged_op.val;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (op_outcomes.size() == 0) begin
          $display("%0t: unexpected transaction: expected none, got ok=%0b removed=%0d count=%0d",
                   $time, ok, removed_value, count);
          mismatches++;
        end else begin
          want = op_outcomes.pop_front();
          if (ok !== want.ok) begin
            $display("%0t: ok mismatch: expected %0b, got %0b", $time, want.ok, ok);
            mismatches++;
          end
          if (removed_value !== want.removed) begin
            $display("%0t: removed_value mismatch: expected %0d, got %0d",
                     $time, want.removed, removed_value);
            mismatches++;
          end
          if (count !== want.count) begin
            $display("%0t: count mismatch: expected %0d, got %0d", $time, want.count, count);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    queue_op(ACT_REM_HEAD, 32'h1234_5678);
    queue_op(ACT_REVERSE, 32'hFFFF_FFFF);
    queue_op(ACT_REM_HEAD, 32'h8000_0000);
    queue_op(ACT_REVERSE, 32'h0);
    queue_op(ACT_INS_HEAD, 32'h8000_0000);
    queue_op(ACT_INS_TAIL, 32'h7FFF_FFFF);
    queue_op(ACT_INS_HEAD, 32'h0);
    queue_op(ACT_INS_TAIL, 32'hFFFF_FFFF);
    queue_op(ACT_REM_HEAD, 32'h7FFF_FFFF);
    queue_op(ACT_REVERSE, 32'h5555_5555);
    queue_op(ACT_REM_HEAD, 32'hAAAA_AAAA);
    queue_op(ACT_INS_HEAD, 32'h5A5A_5A5A);
    queue_op(ACT_INS_TAIL, 32'hA5A5_A5A5);
    queue_op(ACT_REM_HEAD, 32'h0);
    queue_op(ACT_REVERSE, 32'h0);
    queue_op(ACT_REM_HEAD, 32'h0);
    queue_op(ACT_REM_HEAD, 32'hFFFF_FFFF);
    queue_op(ACT_REM_HEAD, 32'h0);
    queue_op(ACT_REM_HEAD, 32'h0);
    queue_op(ACT_REM_HEAD, 32'h0);
    queue_op(ACT_REVERSE, 32'h0);
    queue_op(ACT_REVERSE, 32'h0);
    queue_mix(250, 45, 45);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (op_backlog.size() != 0) @(posedge clk);
    send_idle_pct = 84;
    recv_idle_pct = 31;
    while (gen_level < QDEPTH) queue_mix(1, 92, 5);
    queue_op(ACT_INS_HEAD, pick_value());
    queue_op(ACT_INS_TAIL, pick_value());
    queue_op(ACT_REVERSE, $urandom);
    queue_op(ACT_INS_HEAD, pick_value());
    queue_op(ACT_INS_TAIL, pick_value());
    queue_op(ACT_REM_HEAD, $urandom);
    queue_op(ACT_INS_TAIL, pick_value());
    queue_op(ACT_INS_HEAD, pick_value());

    while (op_backlog.size() != 0) @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_mix(150, 20, 75);
    queue_mix(150, 45, 45);

    while (op_backlog.size() != 0 || in_valid) @(posedge clk);
    while (op_outcomes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && op_outcomes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
